// File: sv/positional_list_with_binary_search_defines.svh
// ---------------------------------------------------------------------------
// positional list assertion macros
// concurrent checks on clk, disabled while rst is high; empty in synthesis
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_WITH_BINARY_SEARCH_DEFINES_SVH
`define POSITIONAL_LIST_WITH_BINARY_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define PLBS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define PLBS_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define PLBS_ASSERT(name, prop, msg)

`define PLBS_ASSERT_NEVER(name, cond, msg)

`endif

`endif

// File: sv/plbs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plbs_pkg
// shared types and constants of the positional list with binary search
// ---------------------------------------------------------------------------
package plbs_pkg;

  // list size and field widths
  localparam int CAPACITY     = 256;
  localparam int PAYLOAD_BITS = 64;
  localparam int IDX_W        = $clog2(CAPACITY);
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int POS_W        = 9;
  localparam int KEY_W        = 32;
  localparam int PAY_W        = 64;
  localparam int CMP_W        = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // request modes
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_SEARCH = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_POS   = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  // request payload
  typedef struct packed {
    mode_t                    mode;
    logic [POS_W-1:0]         position;
    logic signed [KEY_W-1:0]  key;
    logic [PAY_W-1:0]         payload;
  } req_t;

  // result payload
  typedef struct packed {
    status_t                  status;
    logic [POS_W-1:0]         found_position;
    logic signed [KEY_W-1:0]  out_key;
    logic [PAY_W-1:0]         out_payload;
    logic [POS_W-1:0]         entry_count;
  } rsp_t;

  // one list entry as held in a cell
  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic [PAYLOAD_BITS-1:0]  payload;
  } entry_t;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  // broadcast from the controller to the chain
  typedef struct packed {
    cell_op_t                 op;
    logic [IDX_W-1:0]         idx;
    logic signed [KEY_W-1:0]  want;
  } chain_cmd_t;

  // per-cell view of the broadcast
  typedef struct packed {
    cell_op_t op;
    logic     at;
    logic     above;
  } cell_ctl_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAP,
    ST_SHIFT,
    ST_CMP,
    ST_PROBE,
    ST_FINISH
  } ctrl_state_t;

endpackage

// File: sv/plbs_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plbs_cell
// one list slot: holds an entry, takes a neighbor's entry on insert, delete
// or rotate, and registers its key compare against the searched key
// ---------------------------------------------------------------------------
module plbs_cell (
  input  logic                          clk,
  input  plbs_pkg::cell_ctl_t           ctl,
  input  logic signed [31:0]            want,
  input  plbs_pkg::entry_t              prev_entry,
  input  plbs_pkg::entry_t              next_entry,
  input  plbs_pkg::entry_t              new_entry,
  output plbs_pkg::entry_t              entry,
  output logic                          eq,
  output logic                          gt
);
  import plbs_pkg::*;

  entry_t entry_next;

  // slot update
  always_comb begin
    entry_next = entry;
    case (ctl.op)
      CELL_INSERT: begin
        if (ctl.at) begin
          entry_next = new_entry;
        end else if (ctl.above) begin
          entry_next = prev_entry;
        end
      end
      CELL_DELETE: begin
        if (ctl.at || ctl.above) begin
          entry_next = next_entry;
        end
      end
      CELL_ROTATE: begin
        entry_next = next_entry;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  // entry and compare flags
  always_ff @(posedge clk) begin
    entry <= entry_next;
    eq    <= (entry.key == want);
    gt    <= (entry.key > want);
  end

endmodule

// File: sv/plbs_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plbs_ctrl
// request sequencer: checks positions, drives the cell chain, runs the
// halving probe over the compare flags and holds the result register
// ---------------------------------------------------------------------------
module plbs_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  plbs_pkg::req_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output plbs_pkg::rsp_t                    out_data,
  output plbs_pkg::chain_cmd_t              cmd,
  output plbs_pkg::entry_t                  new_entry,
  input  plbs_pkg::entry_t                  head_entry,
  input  logic [plbs_pkg::CAPACITY-1:0]     eq_vec,
  input  logic [plbs_pkg::CAPACITY-1:0]     gt_vec
);
  import plbs_pkg::*;

  ctrl_state_t             state, state_next;
  logic [CNT_W-1:0]        count, count_next;
  logic                    out_valid_next;
  rsp_t                    out_data_next;
  mode_t                   req_mode, req_mode_next;
  logic [IDX_W-1:0]        req_idx, req_idx_next;
  logic signed [KEY_W-1:0] want, want_next;
  logic [IDX_W-1:0]        step, step_next;
  logic [CNT_W-1:0]        lo, lo_next;
  logic [CNT_W-1:0]        hi1, hi1_next;
  status_t                 res_status, res_status_next;
  logic [POS_W-1:0]        res_found, res_found_next;
  entry_t                  res_entry, res_entry_next;
  logic [CMP_W-1:0]        pos_ext;
  logic [CMP_W-1:0]        cnt_ext;
  logic [IDX_W-1:0]        in_idx;
  logic [CNT_W:0]          mid_sum;
  logic [CNT_W-1:0]        mid;
  logic [IDX_W-1:0]        mid_idx;

  // entry built from the request, loaded by the insert cell
  assign new_entry = '{key: in_data.key, payload: PAYLOAD_BITS'(in_data.payload)};

  // position checks against the count
  assign pos_ext = CMP_W'(in_data.position);
  assign cnt_ext = CMP_W'(count);
  assign in_idx  = IDX_W'(in_data.position - POS_W'(1));

  // probe midpoint, floor((lo + hi) / 2) with hi1 = hi + 1
  assign mid_sum = {1'b0, lo} + {1'b0, hi1} - (CNT_W + 1)'(1);
  assign mid     = mid_sum[CNT_W:1];
  assign mid_idx = IDX_W'(mid);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    out_data   <= out_data_next;
    req_mode   <= req_mode_next;
    req_idx    <= req_idx_next;
    want       <= want_next;
    step       <= step_next;
    lo         <= lo_next;
    hi1        <= hi1_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    res_entry  <= res_entry_next;
  end

  // next state and outputs
  always_comb begin
    state_next      = state;
    count_next      = count;
    out_valid_next  = out_valid && !out_ready;
    out_data_next   = out_data;
    req_mode_next   = req_mode;
    req_idx_next    = req_idx;
    want_next       = want;
    step_next       = step;
    lo_next         = lo;
    hi1_next        = hi1;
    res_status_next = res_status;
    res_found_next  = res_found;
    res_entry_next  = res_entry;
    in_ready        = 1'b0;
    cmd.op          = CELL_HOLD;
    cmd.idx         = req_idx;
    cmd.want        = want;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.idx  = in_idx;
        if (in_valid) begin
          req_mode_next   = in_data.mode;
          req_idx_next    = in_idx;
          want_next       = in_data.key;
          step_next       = '0;
          lo_next         = '0;
          hi1_next        = count;
          res_status_next = STAT_OK;
          res_found_next  = '0;
          res_entry_next  = '0;
          unique case (in_data.mode) inside
            MODE_INSERT: begin
              if ((in_data.position == '0) || (pos_ext > cnt_ext + CMP_W'(1))) begin
                res_status_next = STAT_BAD_POS;
              end else if (count == CNT_W'(CAPACITY)) begin
                res_status_next = STAT_FULL;
              end else begin
                cmd.op     = CELL_INSERT;
                count_next = count + CNT_W'(1);
              end
              state_next = ST_FINISH;
            end
            MODE_DELETE, MODE_READ: begin
              if ((in_data.position == '0) || (pos_ext > cnt_ext)) begin
                res_status_next = STAT_BAD_POS;
                state_next      = ST_FINISH;
              end else begin
                state_next = ST_LAP;
              end
            end
            default: begin
              state_next = ST_CMP;
            end
          endcase
        end
      end

      // one full lap of the ring; the wanted entry passes the head
      ST_LAP: begin
        cmd.op = CELL_ROTATE;
        if (step == req_idx) begin
          res_entry_next = head_entry;
        end
        step_next = step + IDX_W'(1);
        if (step == IDX_W'(CAPACITY - 1)) begin
          state_next = (req_mode == MODE_DELETE) ? ST_SHIFT : ST_FINISH;
        end
      end

      // close the gap left by a delete
      ST_SHIFT: begin
        cmd.op     = CELL_DELETE;
        count_next = count - CNT_W'(1);
        state_next = ST_FINISH;
      end

      // cells register their compare against the searched key
      ST_CMP: begin
        state_next = ST_PROBE;
      end

      // one halving step per cycle
      ST_PROBE: begin
        if (lo < hi1) begin
          if (eq_vec[mid_idx]) begin
            res_status_next = STAT_OK;
            res_found_next  = POS_W'(mid + CNT_W'(1));
            state_next      = ST_FINISH;
          end else if (gt_vec[mid_idx]) begin
            hi1_next = mid;
          end else begin
            lo_next = mid + CNT_W'(1);
          end
        end else begin
          res_status_next = STAT_NOT_FOUND;
          state_next      = ST_FINISH;
        end
      end

      // load the output register once it is free
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          out_valid_next               = 1'b1;
          out_data_next.status         = res_status;
          out_data_next.found_position = res_found;
          out_data_next.out_key        = res_entry.key;
          out_data_next.out_payload    = PAY_W'(res_entry.payload);
          out_data_next.entry_count    = POS_W'(count);
          state_next                   = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/positional_list_with_binary_search.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// positional_list_with_binary_search
// ordered list of keyed entries held in a ring of cells: insert, delete and
// read by 1-based position, binary search by key
// ---------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  request   in         in_valid / in_ready  in_data  (req_t)
//  result    out        out_valid/out_ready  out_data (rsp_t)
//
//  insert and every rejected request: accepted, then the result is loaded in ST_FINISH
//  read and delete: the entry is fetched by rotating the whole ring one slot
//  per cycle for one full lap; delete then closes the gap in ST_SHIFT
//  search: ST_CMP, then one halving step per ST_PROBE cycle (at most 9 here),
//  and one more probe on a miss
//  one request at a time; the next is taken while a result waits on out_ready
//  rst clears the count and the handshake; slot contents are not cleared
// ---------------------------------------------------------------------------
`include "positional_list_with_binary_search_defines.svh"

module positional_list_with_binary_search (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  plbs_pkg::req_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output plbs_pkg::rsp_t    out_data
);
  import plbs_pkg::*;

  chain_cmd_t          cmd;
  entry_t              new_entry;
  entry_t              ent [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] gt_vec;

  // sequencer
  plbs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cmd        (cmd),
    .new_entry  (new_entry),
    .head_entry (ent[0]),
    .eq_vec     (eq_vec),
    .gt_vec     (gt_vec)
  );

  // ring of cells, slot 0 is list position 1
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t ctl;

    assign ctl.op    = cmd.op;
    assign ctl.at    = (cmd.idx == IDX_W'(i));
    assign ctl.above = (cmd.idx < IDX_W'(i));

    plbs_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .want       (cmd.want),
      .prev_entry (ent[(i + CAPACITY - 1) % CAPACITY]),
      .next_entry (ent[(i + 1) % CAPACITY]),
      .new_entry  (new_entry),
      .entry      (ent[i]),
      .eq         (eq_vec[i]),
      .gt         (gt_vec[i])
    );
  end

  // checks
  `PLBS_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready,
               "request taken while busy")
  `PLBS_ASSERT(a_found_is_ok,
               out_valid && (out_data.found_position != '0) |-> out_data.status == STAT_OK,
               "found position without ok status")
  `PLBS_ASSERT_NEVER(a_count_range, out_valid && (int'(out_data.entry_count) > CAPACITY),
                     "entry count above capacity")

endmodule
